### rtl/core/kmsw_pkg.sv
// Shared types and constants for the spanning-weight block.
// Has no dependencies. The controller, the datapath and the top level use it.
package kmsw_pkg;

  localparam int SUM_W = 24;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_RD0,
    OP_P1,
    OP_CMP,
    OP_WEND,
    OP_SC0,
    OP_EDGE,
    OP_FA,
    OP_FB,
    OP_SA,
    OP_SB,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_le1;
    logic last_j;
    logic swapped;
    logic root_hit;
    logic same_root;
    logic last_i;
    logic clr_last;
  } sts_t;

endpackage

### rtl/core/kmsw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Has no dependencies.
module kmsw_ram #(
  parameter int W = 8,
  parameter int D = 256,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/kmsw_ctrl.sv
// Sequencer for load, bubble sort passes, union-find scan and table clearing.
// Depends on kmsw_pkg.
module kmsw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_last_edge,
  input  kmsw_pkg::sts_t sts,
  output kmsw_pkg::cmd_t cmd,
  output logic           busy
);

  typedef enum logic [12:0] {
    S_CLR  = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_P0   = 13'b0000000000100,
    S_P1   = 13'b0000000001000,
    S_CMP  = 13'b0000000010000,
    S_WEND = 13'b0000000100000,
    S_SC0  = 13'b0000001000000,
    S_E    = 13'b0000010000000,
    S_FA   = 13'b0000100000000,
    S_FB   = 13'b0001000000000,
    S_SA   = 13'b0010000000000,
    S_SB   = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op = kmsw_pkg::OP_NONE;
    case (state_r)
      S_CLR: begin
        cmd.op = kmsw_pkg::OP_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = kmsw_pkg::OP_LOAD;
          if (in_last_edge) state_nxt = S_P0;
        end
      end
      S_P0: begin
        cmd.op = kmsw_pkg::OP_RD0;
        state_nxt = sts.fill_le1 ? S_SC0 : S_P1;
      end
      S_P1: begin
        cmd.op = kmsw_pkg::OP_P1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.op = kmsw_pkg::OP_CMP;
        if (sts.last_j) state_nxt = S_WEND;
      end
      S_WEND: begin
        cmd.op = kmsw_pkg::OP_WEND;
        state_nxt = sts.swapped ? S_P0 : S_SC0;
      end
      S_SC0: begin
        cmd.op = kmsw_pkg::OP_SC0;
        state_nxt = sts.fill_zero ? S_OUT : S_E;
      end
      S_E: begin
        cmd.op = kmsw_pkg::OP_EDGE;
        state_nxt = S_FA;
      end
      S_FA: begin
        cmd.op = kmsw_pkg::OP_FA;
        if (sts.root_hit) state_nxt = S_FB;
      end
      S_FB: begin
        cmd.op = kmsw_pkg::OP_FB;
        if (sts.root_hit) begin
          if (sts.same_root) state_nxt = sts.last_i ? S_OUT : S_E;
          else state_nxt = S_SA;
        end
      end
      S_SA: begin
        cmd.op = kmsw_pkg::OP_SA;
        state_nxt = S_SB;
      end
      S_SB: begin
        cmd.op = kmsw_pkg::OP_SB;
        state_nxt = sts.last_i ? S_OUT : S_E;
      end
      S_OUT: begin
        cmd.op = kmsw_pkg::OP_OUT;
        state_nxt = S_CLR;
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

### rtl/core/kmsw_dp.sv
// Datapath: edge store, parent and size tables, counters and the weight total.
// Depends on kmsw_pkg and kmsw_ram.
module kmsw_dp #(
  parameter int MAX_NODES   = 256,
  parameter int MAX_EDGES   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kmsw_pkg::cmd_t                cmd,
  output kmsw_pkg::sts_t                sts,
  input  logic [8:0]                    node_count,
  input  logic [7:0]                    in_end_a,
  input  logic [7:0]                    in_end_b,
  input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
  output logic                          out_strobe,
  output logic signed [kmsw_pkg::SUM_W-1:0] out_tree_weight,
  output logic                          out_input_error
);

  localparam int EW = WEIGHT_BITS + 16;
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW = $clog2(MAX_EDGES + 1);
  localparam int NB = $clog2(MAX_NODES);
  localparam int SW = $clog2(MAX_NODES + 1);

  // edge store
  logic          e_we;
  logic [EA-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_q;

  // node tables
  logic          p_we, s_we;
  logic [NB-1:0] p_waddr, p_wdata, p_raddr, p_q;
  logic [NB-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_q;

  logic [FW-1:0] fill_r, j_r, i_r;
  logic          err_r, swapped_r;
  logic [EW-1:0] cur_r;
  logic [NB-1:0] x_r, ra_r, rb_r, b_r, k_r;
  logic [SW-1:0] sa_r;
  logic signed [WEIGHT_BITS-1:0] w_r;
  logic [kmsw_pkg::SUM_W-1:0]    wsum_r;

  logic [31:0] lim;
  logic        in_ok, room, gt, hit, small_a;
  logic [FW-1:0] j_inc, i_inc, fill_inc, fill_dec, j_dec;
  logic signed [WEIGHT_BITS-1:0] cur_w, q_w;
  logic signed [31:0] w_ext;
  logic [NB-1:0] big, child;

  kmsw_ram #(.W(EW), .D(MAX_EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_q)
  );
  kmsw_ram #(.W(NB), .D(MAX_NODES)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_q)
  );
  kmsw_ram #(.W(SW), .D(MAX_NODES)) u_size (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_q)
  );

  assign lim = (32'(node_count) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(node_count);
  assign in_ok = (32'(in_end_a) < lim) && (32'(in_end_b) < lim);
  assign room = (32'(fill_r) < 32'(MAX_EDGES));

  assign j_inc = j_r + 1'b1;
  assign j_dec = j_r - 1'b1;
  assign i_inc = i_r + 1'b1;
  assign fill_inc = fill_r + 1'b1;
  assign fill_dec = fill_r - 1'b1;

  assign cur_w = cur_r[EW-1:16];
  assign q_w = e_q[EW-1:16];
  assign gt = (cur_w > q_w);
  assign hit = (p_q == x_r);
  assign w_ext = 32'(w_r);

  // union by size: smaller group hangs under the larger
  assign small_a = (sa_r < s_q);
  assign big = small_a ? rb_r : ra_r;
  assign child = small_a ? ra_r : rb_r;

  assign sts.fill_zero = (fill_r == '0);
  assign sts.fill_le1 = (fill_r <= FW'(1));
  assign sts.last_j = (j_inc == fill_r);
  assign sts.swapped = swapped_r;
  assign sts.root_hit = hit;
  assign sts.same_root = (p_q == ra_r);
  assign sts.last_i = (i_inc == fill_r);
  assign sts.clr_last = (32'(k_r) == 32'(MAX_NODES - 1));

  always_comb begin
    e_we = 1'b0;
    e_waddr = fill_r[EA-1:0];
    e_wdata = {in_edge_weight, in_end_a, in_end_b};
    e_raddr = '0;
    p_we = 1'b0;
    p_waddr = k_r;
    p_wdata = k_r;
    p_raddr = '0;
    s_we = 1'b0;
    s_waddr = k_r;
    s_wdata = SW'(1);
    s_raddr = '0;
    case (cmd.op)
      kmsw_pkg::OP_LOAD: e_we = in_ok && room;
      kmsw_pkg::OP_CLR: begin
        p_we = 1'b1;
        s_we = 1'b1;
      end
      kmsw_pkg::OP_P1: e_raddr = j_r[EA-1:0];
      kmsw_pkg::OP_CMP: begin
        e_raddr = j_inc[EA-1:0];
        e_we = 1'b1;
        e_waddr = j_dec[EA-1:0];
        e_wdata = gt ? e_q : cur_r;
      end
      kmsw_pkg::OP_WEND: begin
        e_we = 1'b1;
        e_waddr = fill_dec[EA-1:0];
        e_wdata = cur_r;
      end
      kmsw_pkg::OP_EDGE: p_raddr = NB'(e_q[15:8]);
      kmsw_pkg::OP_FA: p_raddr = hit ? b_r : p_q;
      kmsw_pkg::OP_FB: begin
        p_raddr = p_q;
        s_raddr = ra_r;
        e_raddr = i_inc[EA-1:0];
      end
      kmsw_pkg::OP_SA: s_raddr = rb_r;
      kmsw_pkg::OP_SB: begin
        e_raddr = i_inc[EA-1:0];
        p_we = 1'b1;
        p_waddr = child;
        p_wdata = big;
        s_we = 1'b1;
        s_waddr = big;
        s_wdata = sa_r + s_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      err_r <= 1'b0;
      k_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (cmd.op)
        kmsw_pkg::OP_LOAD: begin
          if (in_ok && room) fill_r <= fill_inc;
          else err_r <= 1'b1;
        end
        kmsw_pkg::OP_CLR: k_r <= k_r + 1'b1;
        kmsw_pkg::OP_OUT: begin
          out_strobe <= 1'b1;
          fill_r <= '0;
          err_r <= 1'b0;
          k_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      kmsw_pkg::OP_RD0: begin
        j_r <= FW'(1);
        swapped_r <= 1'b0;
      end
      kmsw_pkg::OP_P1: cur_r <= e_q;
      kmsw_pkg::OP_CMP: begin
        if (!gt) cur_r <= e_q;
        if (gt) swapped_r <= 1'b1;
        j_r <= j_inc;
      end
      kmsw_pkg::OP_SC0: begin
        i_r <= '0;
        wsum_r <= '0;
      end
      kmsw_pkg::OP_EDGE: begin
        x_r <= NB'(e_q[15:8]);
        b_r <= NB'(e_q[7:0]);
        w_r <= e_q[EW-1:16];
      end
      kmsw_pkg::OP_FA: begin
        if (hit) begin
          ra_r <= x_r;
          x_r <= b_r;
        end else begin
          x_r <= p_q;
        end
      end
      kmsw_pkg::OP_FB: begin
        if (hit) begin
          rb_r <= x_r;
          if (x_r == ra_r) i_r <= i_inc;
        end else begin
          x_r <= p_q;
        end
      end
      kmsw_pkg::OP_SA: sa_r <= s_q;
      kmsw_pkg::OP_SB: begin
        wsum_r <= wsum_r + w_ext[kmsw_pkg::SUM_W-1:0];
        i_r <= i_inc;
      end
      kmsw_pkg::OP_OUT: begin
        out_tree_weight <= wsum_r;
        out_input_error <= err_r;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/kruskal_min_spanning_weight.sv
// Top level of the minimum spanning forest weight engine.
// Depends on kmsw_pkg, kmsw_ctrl, kmsw_dp and kmsw_ram.
//
// Edges are issued with start while busy is low, one per cycle, until one
// with in_last_edge set. The block then bubble-sorts the stored edges by
// weight in its edge RAM (one compare per cycle, up to fill passes), scans
// them through a union-find table with union by size (parent chains at most
// log2 of the node count deep), and raises out_strobe for exactly one cycle
// with the 24-bit wrapped total and the error flag. The receiver cannot stall
// the result; it must take it in that cycle. After each result, and after
// reset, a clearing pass over all MAX_NODES entries rewrites the parent
// and size tables while busy stays high; configuration writes are taken
// at any time. Edges with an endpoint at or above node_count (capped at
// MAX_NODES), or that arrive with the store full, are dropped and set
// out_input_error.
module kruskal_min_spanning_weight #(
  parameter int MAX_NODES   = 256,
  parameter int MAX_EDGES   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // edge command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_end_a,
  input  logic [7:0]                    in_end_b,
  input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
  input  logic                          in_last_edge,
  // result
  output logic                          out_strobe,
  output logic signed [kmsw_pkg::SUM_W-1:0] out_tree_weight,
  output logic                          out_input_error,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [0:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  kmsw_pkg::cmd_t cmd;
  kmsw_pkg::sts_t sts;
  logic [8:0] cfg_node_count_r;

  // node_count register, single register at byte address 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_node_count_r <= 9'd256;
    end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
      cfg_node_count_r <= pwdata[8:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {23'd0, cfg_node_count_r} : 32'd0;

  kmsw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_last_edge(in_last_edge),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  kmsw_dp #(
    .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .node_count(cfg_node_count_r),
    .in_end_a(in_end_a), .in_end_b(in_end_b), .in_edge_weight(in_edge_weight),
    .out_strobe(out_strobe), .out_tree_weight(out_tree_weight),
    .out_input_error(out_input_error)
  );

endmodule
